@@ rtl/core/double_ended_queue_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue unit
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// expr holds at every clock edge out of reset
`define DQ_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("%m: check failed");
// when a holds, b holds in the same cycle
`define DQ_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("%m: check failed");
// when a holds, b holds in the next cycle
`define DQ_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("%m: check failed");
`else
`define DQ_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define DQ_ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define DQ_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

@@ rtl/core/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Word types, action and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [2:0] ACT_POP_BACK   = 3'd3;
	localparam logic [2:0] ACT_DUMP       = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// read address sources
	localparam logic [1:0] RD_FRONT = 2'd0;
	localparam logic [1:0] RD_BACK  = 2'd1;
	localparam logic [1:0] RD_WALK  = 2'd2;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] item_value;
		logic [1:0]         status;
		logic               last;
	} res_t;

	typedef struct packed {
		logic       load;
		logic       wr_front;
		logic       wr_back;
		logic       pop_front;
		logic       pop_back;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       walk_start;
		logic       walk_step;
		logic       out_en;
		logic       out_data;
		logic [1:0] out_status;
		logic       out_walk_last;
	} dq_cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic       empty;
		logic       full;
		logic       walk_last;
	} dq_stat_t;

endpackage

@@ rtl/core/double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit words held in a ring.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Every result word is
// shown on result for exactly one cycle while strobe is high; the receiver
// cannot hold it off, so it must take each one as it comes. A push, a failed
// pop, a dump of an empty store or an unused action gives its single result
// from the result register after the request register, and the unit takes
// the next word in the same cycle as that result is shown. A pop needs a read
// of the ring memory, whose read data is registered, so its result also passes
// through the read data register and no new word is taken before it. A dump of
// N entries gives N results on consecutive cycles; only its final result has
// last set. The ring holds DEPTH words; no clearing pass follows reset.
// ----------------------------------------------------------------------------
module double_ended_queue_unit import deq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output res_t result,
	output logic strobe
);

	dq_cmd_t  cmd;
	dq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	deq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result),
		.strobe  (strobe)
	);

endmodule

@@ rtl/core/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: decodes the latched action and steps the datapath.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dq_stat_t stat,
	output dq_cmd_t  cmd,
	output logic     busy
);

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_DECODE  = 2'd1;
	localparam logic [1:0] S_POPWAIT = 2'd2;
	localparam logic [1:0] S_DUMP    = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.rd_sel     = RD_FRONT;
		cmd.out_status = ST_OK;
		state_d        = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				case (stat.action)
					ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
						cmd.out_en = 1'b1;
						if (stat.full) begin
							cmd.out_status = ST_FULL;
						end else if (stat.action == ACT_PUSH_FRONT) begin
							cmd.wr_front = 1'b1;
						end else begin
							cmd.wr_back = 1'b1;
						end
					end
					ACT_POP_FRONT, ACT_POP_BACK: begin
						if (stat.empty) begin
							cmd.out_en     = 1'b1;
							cmd.out_status = ST_EMPTY;
						end else begin
							cmd.rd_en = 1'b1;
							if (stat.action == ACT_POP_FRONT) begin
								cmd.rd_sel    = RD_FRONT;
								cmd.pop_front = 1'b1;
							end else begin
								cmd.rd_sel   = RD_BACK;
								cmd.pop_back = 1'b1;
							end
							state_d = S_POPWAIT;
						end
					end
					ACT_DUMP: begin
						if (stat.empty) begin
							cmd.out_en     = 1'b1;
							cmd.out_status = ST_EMPTY;
						end else begin
							cmd.rd_en      = 1'b1;
							cmd.rd_sel     = RD_FRONT;
							cmd.walk_start = 1'b1;
							state_d        = S_DUMP;
						end
					end
					default: begin
						// unused code: answer ok with no effect
						cmd.out_en = 1'b1;
					end
				endcase
			end
			S_POPWAIT: begin
				cmd.out_en   = 1'b1;
				cmd.out_data = 1'b1;
				state_d      = S_IDLE;
			end
			S_DUMP: begin
				// emit the entry read last cycle, fetch the next one
				cmd.out_en        = 1'b1;
				cmd.out_data      = 1'b1;
				cmd.out_walk_last = 1'b1;
				cmd.rd_en         = 1'b1;
				cmd.rd_sel        = RD_WALK;
				cmd.walk_step     = 1'b1;
				if (stat.walk_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/deq_dpath.sv @@
// ----------------------------------------------------------------------------
// deq_dpath
// Ring storage, front pointer, entry count, dump walker and result register.
// ----------------------------------------------------------------------------
`include "double_ended_queue_unit_assert.svh"

module deq_dpath import deq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     request,
	input  dq_cmd_t  cmd,
	output dq_stat_t stat,
	output res_t     result,
	output logic     strobe
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = PW + 1;

	localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
	localparam logic [SW-1:0] SUM_WRAP = SW'(DEPTH);

	logic [31:0]   mem_q [DEPTH];
	logic [31:0]   rdata_q;
	req_t          req_q;
	logic [PW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] walk_ptr_q;
	logic [CW-1:0] walk_cnt_q;
	res_t          result_q;
	logic          strobe_q;

	logic [PW-1:0] front_inc;
	logic [PW-1:0] front_dec;
	logic [PW-1:0] walk_inc;
	logic [SW-1:0] tail_sum;
	logic [SW-1:0] back_sum;
	logic [PW-1:0] tail_ptr;
	logic [PW-1:0] back_ptr;
	logic [PW-1:0] waddr;
	logic [PW-1:0] raddr;
	logic          walk_last;

	assign front_inc = (front_q == PTR_MAX) ? '0 : front_q + PW'(1);
	assign front_dec = (front_q == '0) ? PTR_MAX : front_q - PW'(1);
	assign walk_inc  = (walk_ptr_q == PTR_MAX) ? '0 : walk_ptr_q + PW'(1);

	// slot after the back entry, and the back entry itself
	assign tail_sum = SW'(front_q) + SW'(count_q);
	assign back_sum = tail_sum - SW'(1);
	assign tail_ptr = (tail_sum >= SUM_WRAP) ? PW'(tail_sum - SUM_WRAP) : PW'(tail_sum);
	assign back_ptr = (back_sum >= SUM_WRAP) ? PW'(back_sum - SUM_WRAP) : PW'(back_sum);

	assign walk_last = (walk_cnt_q == count_q - CW'(1));

	assign waddr = cmd.wr_front ? front_dec : tail_ptr;

	always_comb begin
		case (cmd.rd_sel)
			RD_FRONT: raddr = front_q;
			RD_BACK:  raddr = back_ptr;
			RD_WALK:  raddr = walk_ptr_q;
			default:  raddr = front_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_front || cmd.wr_back) begin
			mem_q[waddr] <= req_q.value;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
		end
		if (cmd.out_en) begin
			result_q.item_value <= cmd.out_data ? $signed(rdata_q) : '0;
			result_q.status     <= cmd.out_status;
			result_q.last       <= cmd.out_walk_last ? walk_last : 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			count_q    <= '0;
			walk_ptr_q <= '0;
			walk_cnt_q <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= cmd.out_en;
			if (cmd.wr_front) begin
				front_q <= front_dec;
			end else if (cmd.pop_front) begin
				front_q <= front_inc;
			end
			if (cmd.wr_front || cmd.wr_back) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop_front || cmd.pop_back) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.walk_start) begin
				walk_ptr_q <= front_inc;
				walk_cnt_q <= '0;
			end else if (cmd.walk_step) begin
				walk_ptr_q <= walk_inc;
				walk_cnt_q <= walk_cnt_q + CW'(1);
			end
		end
	end

	assign stat.action    = req_q.action;
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == CNT_FULL);
	assign stat.walk_last = walk_last;

	assign result = result_q;
	assign strobe = strobe_q;

	`DQ_ASSERT_ALWAYS(a_count_bound, clk, arst_n, SW'(count_q) <= SUM_WRAP)
	`DQ_ASSERT_ALWAYS(a_front_bound, clk, arst_n, SW'(front_q) < SUM_WRAP)
	`DQ_ASSERT_IMPL(a_no_push_full, clk, arst_n, cmd.wr_front || cmd.wr_back, !stat.full)
	`DQ_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, cmd.pop_front || cmd.pop_back, !stat.empty)
	`DQ_ASSERT_NEXT(a_push_grows, clk, arst_n, cmd.wr_front || cmd.wr_back, count_q == $past(count_q) + CW'(1))

endmodule
